### design/fir_pkg.sv
// shared types and constants for the q15 fir filter
package fir_pkg;

	// filter size and field widths
	localparam int MAX_TAPS = 64;
	localparam int TAP_W    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int TC_W     = 7;
	localparam int IDX_W    = 6;
	localparam int SMP_W    = 16;
	localparam int PROD_W   = 2 * SMP_W;
	localparam int ACC_W    = PROD_W + TAP_W;
	localparam int FRAC_W   = 15;

	// rounding and q30 clamp limits
	localparam logic signed [ACC_W-1:0] ROUND_CONST = ACC_W'(1 << 14);
	localparam logic signed [ACC_W-1:0] SAT_HIGH    = ACC_W'(64'sh3fff_ffff);
	localparam logic signed [ACC_W-1:0] SAT_LOW     = ACC_W'(-64'sh4000_0000);

	// request codes
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_COEF   = 1'b1;

	// input beat
	typedef struct packed {
		logic                    req_type;
		logic signed [SMP_W-1:0] sample_in;
		logic [IDX_W-1:0]        coef_index;
		logic signed [SMP_W-1:0] coef_value;
		logic                    block_end;
	} req_t;

	// result beat
	typedef struct packed {
		logic signed [SMP_W-1:0] filtered_out;
		logic                    block_end_out;
	} res_t;

	// per-cell control from the top level
	typedef struct packed {
		logic shift;
		logic coef_we;
		logic start;
	} cell_ctl_t;

	// partial sum moving from one cell to its lower neighbor
	typedef struct packed {
		logic                    act;
		logic signed [ACC_W-1:0] psum;
	} link_t;

endpackage

### design/fir_filter_q15.sv
// top level of the streaming q15 fir filter built as a row of tap cells
// A coefficient write beat gives no result. A sample beat shifts the sample into the
// row of tap cells, and the running sum then starts at the last tap in use and walks
// one cell per cycle down to cell zero (a tap_count of zero counts as one tap, above
// 64 as 64); the next beat is taken in the cycle after the result of that sample
// lands in the output register. A finished result may wait in the output register
// while the next sample runs. Tap count is written through cfg_we and cfg_wdata; the
// user must do so only while the filter is idle, the block itself does not enforce
// this. History and coefficients reset to zero.
module fir_filter_q15 (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [fir_pkg::TC_W-1:0]  cfg_wdata,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  fir_pkg::req_t             req,
	output logic                      res_valid,
	input  logic                      res_stall,
	output fir_pkg::res_t             res
);
	import fir_pkg::*;

	logic [TC_W-1:0]         tap_count_q;
	logic [TAP_W-1:0]        last_tap;
	logic                    smp_acc;
	logic                    coef_acc;
	logic                    go_s1;
	logic                    go_s2;
	logic                    pass_q;
	logic                    bend_q;
	logic                    done;
	logic                    out_ok;
	logic signed [ACC_W-1:0] clamp;
	res_t                    fmt;
	res_t                    out_q;
	logic                    out_valid_q;
	res_t                    pend_q;
	logic                    pend_valid_q;
	logic [MAX_TAPS-1:0]     act_vec;

	cell_ctl_t               ctl_w  [MAX_TAPS];
	logic signed [SMP_W-1:0] x_in_w [MAX_TAPS];
	logic signed [SMP_W-1:0] x_out_w[MAX_TAPS];
	link_t                   lin_w  [MAX_TAPS];
	link_t                   lout_w [MAX_TAPS];

	// input handshake
	assign req_stall = pass_q | pend_valid_q;
	assign smp_acc   = req_valid && !req_stall && (req.req_type == REQ_SAMPLE);
	assign coef_acc  = req_valid && !req_stall && (req.req_type == REQ_COEF);

	// tap count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TC_W'(MAX_TAPS);
		end else if (cfg_we) begin
			tap_count_q <= cfg_wdata;
		end
	end

	// index of the last tap in use
	always_comb begin
		if (tap_count_q == '0) begin
			last_tap = '0;
		end else if (tap_count_q > TC_W'(MAX_TAPS)) begin
			last_tap = TAP_W'(MAX_TAPS - 1);
		end else begin
			last_tap = TAP_W'(tap_count_q - 1'b1);
		end
	end

	// cell row: samples flow up, partial sums flow down
	for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
		assign ctl_w[k].shift   = smp_acc;
		assign ctl_w[k].coef_we = coef_acc && (32'(req.coef_index) == k);
		assign ctl_w[k].start   = go_s2 && (last_tap == TAP_W'(k));
		assign act_vec[k]       = lout_w[k].act;

		if (k == 0) begin : g_head
			assign x_in_w[k] = req.sample_in;
		end else begin : g_body
			assign x_in_w[k] = x_out_w[k-1];
		end

		if (k == MAX_TAPS - 1) begin : g_tail
			assign lin_w[k] = '0;
		end else begin : g_link
			assign lin_w[k] = lout_w[k+1];
		end

		fir_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl_w[k]),
			.x_in     (x_in_w[k]),
			.coef_in  (req.coef_value),
			.link_in  (lin_w[k]),
			.x_out    (x_out_w[k]),
			.link_out (lout_w[k])
		);
	end

	assign done = lout_w[0].act;

	// pass sequencing: product settles, then the sum is seeded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s1  <= 1'b0;
			go_s2  <= 1'b0;
			pass_q <= 1'b0;
		end else begin
			go_s1 <= smp_acc;
			go_s2 <= go_s1;
			if (smp_acc) begin
				pass_q <= 1'b1;
			end else if (done) begin
				pass_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (smp_acc) begin
			bend_q <= req.block_end;
		end
	end

	// clamp to q30 and drop the fraction bits
	always_comb begin
		if (lout_w[0].psum > SAT_HIGH) begin
			clamp = SAT_HIGH;
		end else if (lout_w[0].psum < SAT_LOW) begin
			clamp = SAT_LOW;
		end else begin
			clamp = lout_w[0].psum;
		end
		fmt.filtered_out  = clamp[FRAC_W+SMP_W-1:FRAC_W];
		fmt.block_end_out = bend_q;
	end

	// output register with a one-beat holding slot behind it
	assign out_ok = !out_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (pend_valid_q && out_ok) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else if (done && out_ok) begin
				out_valid_q <= 1'b1;
			end else if (done) begin
				pend_valid_q <= 1'b1;
			end else if (out_valid_q && !res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_valid_q && out_ok) begin
			out_q <= pend_q;
		end else if (done && out_ok) begin
			out_q <= fmt;
		end else if (done) begin
			pend_q <= fmt;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

	// checks on the pass control
	a_one_sum: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(act_vec))
		else $error("more than one running sum in the cell row");

	a_done_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> pass_q)
		else $error("sum reached cell zero outside a pass");

	a_pend_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> out_valid_q)
		else $error("holding slot filled while output register empty");

	a_sample_starts_pass: assert property (@(posedge clk) disable iff (!arst_n)
		smp_acc |=> (pass_q && go_s1))
		else $error("accepted sample did not start a pass");

endmodule

### design/fir_cell.sv
// one tap cell: sample register, coefficient, product and partial sum stage
module fir_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  fir_pkg::cell_ctl_t               ctl,
	input  logic signed [fir_pkg::SMP_W-1:0] x_in,
	input  logic signed [fir_pkg::SMP_W-1:0] coef_in,
	input  fir_pkg::link_t                   link_in,
	output logic signed [fir_pkg::SMP_W-1:0] x_out,
	output fir_pkg::link_t                   link_out
);
	import fir_pkg::*;

	logic signed [SMP_W-1:0]  x_q;
	logic signed [SMP_W-1:0]  coef_q;
	logic signed [PROD_W-1:0] prod_q;
	logic                     act_q;
	logic signed [ACC_W-1:0]  psum_q;

	// sample history, coefficient and tap product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q    <= '0;
			coef_q <= '0;
			prod_q <= '0;
		end else begin
			if (ctl.shift) begin
				x_q <= x_in;
			end
			if (ctl.coef_we) begin
				coef_q <= coef_in;
			end
			prod_q <= coef_q * x_q;
		end
	end

	// activity marker of the running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else begin
			act_q <= ctl.start | link_in.act;
		end
	end

	// partial sum: seeded with the rounding term at the last tap, else accumulated
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			psum_q <= ROUND_CONST + ACC_W'(prod_q);
		end else begin
			psum_q <= link_in.psum + ACC_W'(prod_q);
		end
	end

	assign x_out         = x_q;
	assign link_out.act  = act_q;
	assign link_out.psum = psum_q;

endmodule

### bench/testbench.sv
// self-checking testbench for the streaming q15 fir filter
module testbench;
	import fir_pkg::*;

	localparam int  SETTLE_CYCLES = 80;
	localparam int  CYCLE_LIMIT   = 600000;
	localparam int  PHASE_ITEMS   = 72;
	localparam int  PHASE_COUNT   = 12;
	localparam longint ACC_HIGH   = 64'sh3fff_ffff;
	localparam longint ACC_LOW    = -64'sh4000_0000;
	localparam longint ROUND_HALF = 64'sd16384;

	typedef enum logic {ROW_BEAT, ROW_TAPS} row_kind_t;

	typedef struct {
		row_kind_t       kind;
		req_t            beat;
		logic [TC_W-1:0] taps;
		bit              has_exp;
		res_t            exp;
	} plan_row_t;

	logic            clk       = 1'b0;
	logic            arst_n    = 1'b0;
	logic            cfg_we    = 1'b0;
	logic [TC_W-1:0] cfg_wdata = '0;
	logic            req_valid = 1'b0;
	logic            req_stall;
	req_t            req       = '0;
	logic            res_valid;
	logic            res_stall = 1'b0;
	res_t            res;

	// typed-in expectation that rides along with a directed beat
	bit   pin_en  = 1'b0;
	res_t pin_val = '0;

	// predictor state
	logic signed [SMP_W-1:0] hist  [0:MAX_TAPS-2];
	logic signed [SMP_W-1:0] coefs [0:MAX_TAPS-1];
	logic [TC_W-1:0]         cur_taps = TC_W'(MAX_TAPS);
	res_t                    pending_y [$];
	plan_row_t               plan [$];

	bit idle_on   = 1'b1;
	int hold_left = 0;
	int cycle_cnt = 0;
	int n_err     = 0;
	int n_sample  = 0;
	int n_coef    = 0;
	int n_result  = 0;
	int n_cfg     = 0;

	fir_filter_q15 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always #2 clk = ~clk;

	// run-length guard
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// one filter output for a new sample, then shift it into the history
	function automatic res_t filter_sample(input logic signed [SMP_W-1:0] x, input logic be);
		longint acc;
		int     taps;
		int     k;
		res_t   r;
		taps = (cur_taps == 0) ? 1 : ((cur_taps > MAX_TAPS) ? MAX_TAPS : int'(cur_taps));
		acc = ROUND_HALF + longint'(coefs[0]) * longint'(x);
		for (k = 1; k < taps; k++)
			acc += longint'(coefs[k]) * longint'(hist[k-1]);
		if (acc > ACC_HIGH)
			acc = ACC_HIGH;
		else if (acc < ACC_LOW)
			acc = ACC_LOW;
		acc = acc >>> FRAC_W;
		r.filtered_out  = acc[SMP_W-1:0];
		r.block_end_out = be;
		for (k = MAX_TAPS - 2; k >= 1; k--)
			hist[k] = hist[k-1];
		hist[0] = x;
		return r;
	endfunction

	// mostly uniform, sometimes a corner value
	function automatic logic signed [SMP_W-1:0] pick_q15();
		case ($urandom_range(0, 11))
			0:       return 16'sh7fff;
			1:       return 16'sh8000;
			2:       return '0;
			3:       return '1;
			default: return SMP_W'($urandom);
		endcase
	endfunction

	function automatic req_t random_beat(input int eff);
		req_t b;
		b.req_type   = ($urandom_range(0, 3) == 0) ? REQ_COEF : REQ_SAMPLE;
		b.sample_in  = pick_q15();
		b.coef_index = $urandom_range(0, 1) ? IDX_W'($urandom_range(0, eff - 1))
		                                    : IDX_W'($urandom);
		b.coef_value = pick_q15();
		b.block_end  = 1'($urandom_range(0, 1));
		return b;
	endfunction

	// directed plan rows
	function automatic void plan_sample(input logic signed [SMP_W-1:0] x, input logic be,
	                                    input bit has_exp, input logic signed [SMP_W-1:0] y);
		plan_row_t row;
		row.kind    = ROW_BEAT;
		row.beat    = '{req_type: REQ_SAMPLE, sample_in: x, coef_index: IDX_W'($urandom),
		                coef_value: SMP_W'($urandom), block_end: be};
		row.taps    = '0;
		row.has_exp = has_exp;
		row.exp     = '{filtered_out: y, block_end_out: be};
		plan.push_back(row);
	endfunction

	function automatic void plan_coef(input logic [IDX_W-1:0] idx,
	                                  input logic signed [SMP_W-1:0] c, input logic be);
		plan_row_t row;
		row.kind    = ROW_BEAT;
		row.beat    = '{req_type: REQ_COEF, sample_in: SMP_W'($urandom), coef_index: idx,
		                coef_value: c, block_end: be};
		row.taps    = '0;
		row.has_exp = 1'b0;
		row.exp     = '0;
		plan.push_back(row);
	endfunction

	function automatic void plan_taps(input logic [TC_W-1:0] t);
		plan_row_t row;
		row.kind    = ROW_TAPS;
		row.beat    = '0;
		row.taps    = t;
		row.has_exp = 1'b0;
		row.exp     = '0;
		plan.push_back(row);
	endfunction

	// present one beat after a random gap and hold it until taken
	task automatic send_beat(input req_t b, input bit has_exp, input res_t e);
		int gap;
		gap = idle_on ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= b;
		pin_en    <= has_exp;
		pin_val   <= e;
		do @(posedge clk); while (req_stall);
		if (b.req_type == REQ_COEF)
			n_coef++;
		else
			n_sample++;
	endtask

	// stop sending, wait for every output, then let the pipe settle
	task automatic drain_filter();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_y.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_taps(input logic [TC_W-1:0] t);
		drain_filter();
		cfg_we    <= 1'b1;
		cfg_wdata <= t;
		@(posedge clk);
		cfg_we <= 1'b0;
		n_cfg++;
	endtask

	// output side back-pressure, redrawn after every taken beat
	always @(posedge clk) begin
		if (res_valid && !res_stall)
			hold_left = idle_on ? $urandom_range(0, 16) : 0;
		else if (hold_left > 0)
			hold_left--;
		res_stall <= (hold_left > 0);
	end

	// track accepted beats in the predictor and check outputs
	always @(posedge clk) begin : check_beats
		res_t want;
		if (arst_n) begin
			if (cfg_we)
				cur_taps = cfg_wdata;
			if (req_valid && !req_stall) begin
				if (req.req_type == REQ_COEF) begin
					coefs[req.coef_index] = req.coef_value;
				end else begin
					want = filter_sample(req.sample_in, req.block_end);
					if (pin_en)
						want = pin_val;
					pending_y.push_back(want);
				end
			end
			if (res_valid && !res_stall) begin
				n_result++;
				if (pending_y.size() == 0) begin
					$error("output beat with none expected: filtered_out %0d", res.filtered_out);
					n_err++;
				end else begin
					want = pending_y.pop_front();
					if (res.filtered_out !== want.filtered_out) begin
						$error("filtered_out expected %0d actual %0d",
						       want.filtered_out, res.filtered_out);
						n_err++;
					end
					if (res.block_end_out !== want.block_end_out) begin
						$error("block_end_out expected %0d actual %0d",
						       want.block_end_out, res.block_end_out);
						n_err++;
					end
				end
			end
		end
	end

	// stimulus
	initial begin
		int              p;
		int              i;
		int              k;
		int              eff;
		int              stretch;
		int              tap_list [10];
		logic [TC_W-1:0] tc;
		plan_row_t       row;
		req_t            b;

		for (k = 0; k < MAX_TAPS - 1; k++)
			hist[k] = '0;
		for (k = 0; k < MAX_TAPS; k++)
			coefs[k] = '0;
		tap_list = '{1, 64, 0, 127, 3, 8, 16, 2, 32, 65};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero taps after reset, clamp both ways, max index, tap count corners
		plan_sample(16'sh7fff, 1'b1, 1'b1, 16'sd0);
		plan_sample(16'sh8000, 1'b0, 1'b1, 16'sd0);
		plan_coef(6'd0, 16'sh8000, 1'b1);
		plan_sample(16'sh8000, 1'b0, 1'b1, 16'sh7fff);
		plan_coef(6'd63, 16'sh7fff, 1'b0);
		plan_coef(6'd1, 16'sh8000, 1'b1);
		plan_sample(16'sh7fff, 1'b1, 1'b0, '0);
		plan_sample(16'sh7fff, 1'b0, 1'b1, 16'sh8000);
		plan_coef(6'd0, 16'sd0, 1'b0);
		plan_coef(6'd1, 16'sd0, 1'b0);
		plan_sample(16'sd0, 1'b1, 1'b1, 16'sd0);
		plan_taps(7'd0);
		plan_coef(6'd0, 16'sh4000, 1'b0);
		plan_coef(6'd1, 16'sh7fff, 1'b1);
		plan_sample(16'sh8000, 1'b1, 1'b0, '0);
		plan_taps(7'd127);
		plan_sample(16'sd12345, 1'b0, 1'b0, '0);
		plan_taps(7'd2);
		plan_sample(-16'sd1, 1'b1, 1'b0, '0);
		plan_taps(7'd64);
		plan_sample(16'sd1, 1'b1, 1'b0, '0);

		foreach (plan[r]) begin
			row = plan[r];
			if (row.kind == ROW_TAPS)
				set_taps(row.taps);
			else
				send_beat(row.beat, row.has_exp, row.exp);
		end

		// random phases, each under its own tap count
		stretch = $urandom_range(20, 80);
		for (p = 0; p < PHASE_COUNT; p++) begin
			tc = (p < 10) ? TC_W'(tap_list[p]) : TC_W'($urandom_range(1, 20));
			set_taps(tc);
			eff = (tc == 0) ? 1 : ((tc > MAX_TAPS) ? MAX_TAPS : int'(tc));
			// often load the taps in use before streaming
			if ($urandom_range(0, 1)) begin
				for (k = 0; k < eff; k++) begin
					b = '{req_type: REQ_COEF, sample_in: SMP_W'($urandom),
					      coef_index: IDX_W'(k), coef_value: pick_q15(),
					      block_end: 1'($urandom_range(0, 1))};
					send_beat(b, 1'b0, '0);
				end
			end
			for (i = 0; i < PHASE_ITEMS; i++) begin
				send_beat(random_beat(eff), 1'b0, '0);
				if ($urandom_range(0, 149) == 0)
					drain_filter();
				stretch--;
				if (stretch == 0) begin
					idle_on = ~idle_on;
					stretch = $urandom_range(20, 80);
				end
			end
		end

		drain_filter();
		$display("covered %0d samples and %0d tap writes over %0d tap count settings",
		         n_sample, n_coef, n_cfg);
		$display("checked %0d output beats, %0d mismatches", n_result, n_err);
		if (n_err == 0 && pending_y.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
